// ===== hdl/gys_pkg.sv =====
// Package for the gimbal yaw/pitch servo step block: types, profile tables, constants.
// No dependencies.
`default_nettype none
package gys_pkg;
  localparam int AngleFracBits = 12;
  localparam int FiltFracBits = 14;
  localparam int Ffx = 8;
  localparam int Ix = 7;
  localparam int DampSh = AngleFracBits - 6 + FiltFracBits;

  typedef enum logic [1:0] {PROF_NORMAL = 2'd0, PROF_MID = 2'd1, PROF_HIGH = 2'd2} profile_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_FFMUL, ST_ALPHA, ST_INT, ST_DAMP, ST_DONE
  } state_t;

  localparam logic [2:0] CFG_MID_ENTER  = 3'd0;
  localparam logic [2:0] CFG_MID_EXIT   = 3'd1;
  localparam logic [2:0] CFG_HIGH_ENTER = 3'd2;
  localparam logic [2:0] CFG_HIGH_EXIT  = 3'd3;
  localparam logic [2:0] CFG_IWIN       = 3'd4;
  localparam logic [2:0] CFG_FFNEG      = 3'd5;

  localparam logic signed [17:0] PI_Q = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q = 18'sd25736;
  localparam logic signed [17:0] PITCH_UP = 18'sd1434;
  localparam logic signed [17:0] PITCH_DOWN = -18'sd1843;
  localparam logic [15:0] LEAK_Q = 16'd16302;

  typedef struct packed {
    logic [15:0] deadband;
    logic [15:0] damp;
    logic [15:0] ffgain;
    logic [23:0] fflim;
    logic [23:0] ffstep;
    logic [15:0] alpha;
    logic [15:0] igain;
    logic [23:0] ilim;
  } prof_k_t;

  function automatic prof_k_t prof_k(input logic [1:0] p);
    prof_k_t k;
    case (p)
      PROF_MID: begin
        k = '{16'd20, 16'd1258, 16'd35226, 24'd3768320, 24'd32768, 16'd524, 16'd3020, 24'd73400};
      end
      PROF_HIGH: begin
        k = '{16'd18, 16'd1468, 16'd37683, 24'd4587520, 24'd39322, 16'd492, 16'd3607, 24'd94372};
      end
      default: begin
        k = '{16'd16, 16'd0, 16'd32768, 24'd3276800, 24'd26214, 16'd655, 16'd2307, 24'd52429};
      end
    endcase
    return k;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/gys_if.sv =====
// Valid/ready channel interfaces for the servo step block.
// Depends on nothing.
`default_nettype none
interface gys_in_if;
  logic valid;
  logic ready;
  logic enable;
  logic signed [15:0] yaw_target, gimbal_yaw, motor_yaw, chassis_rate, gimbal_rate;
  logic signed [15:0] pitch_target, gimbal_pitch, motor_pitch;
  modport source (output valid, enable, yaw_target, gimbal_yaw, motor_yaw, chassis_rate,
                  gimbal_rate, pitch_target, gimbal_pitch, motor_pitch, input ready);
  modport sink (input valid, enable, yaw_target, gimbal_yaw, motor_yaw, chassis_rate,
                gimbal_rate, pitch_target, gimbal_pitch, motor_pitch, output ready);
endinterface

interface gys_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] yaw_drive, yaw_feedforward;
  logic signed [11:0] pitch_drive;
  logic [1:0] profile;
  logic profile_changed, drive_valid;
  modport source (output valid, yaw_drive, yaw_feedforward, pitch_drive, profile,
                  profile_changed, drive_valid, input ready);
  modport sink (input valid, yaw_drive, yaw_feedforward, pitch_drive, profile,
                profile_changed, drive_valid, output ready);
endinterface
`default_nettype wire

// ===== hdl/gys_sermul.sv =====
// Shift-add serial multiplier, two multiplier bits per cycle, signed multiplicand a, unsigned multiplier b.
// Depends on gys_pkg.
`default_nettype none
module gys_sermul
  import gys_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic signed [25:0] a,
  input  wire logic [15:0] b,
  output logic done,
  output logic signed [42:0] p
);
  logic signed [42:0] acc_r, acc_nxt;
  logic signed [42:0] mc_r, mc_nxt;
  logic [15:0] mb_r, mb_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic signed [42:0] add;

  always_comb begin
    add = (mb_r[0] ? mc_r : 43'sd0) + (mb_r[1] ? (mc_r <<< 1) : 43'sd0);
    acc_nxt = acc_r;
    mc_nxt = mc_r;
    mb_nxt = mb_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      acc_nxt = '0;
      mc_nxt = 43'(a);
      mb_nxt = b;
      cnt_nxt = 4'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + add;
      mc_nxt = mc_r <<< 2;
      mb_nxt = mb_r >> 2;
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd7) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mc_r <= mc_nxt;
    mb_r <= mb_nxt;
  end

  assign done = busy_r && (cnt_r == 4'd7);
  assign p = acc_r + add;
endmodule
`default_nettype wire

// ===== hdl/gimbal_yaw_pitch_servo_step_core.sv =====
// Top level of the gimbal yaw/pitch servo step block.
// Depends on gys_pkg, gys_if and gys_sermul.
//
// Usage: one input transaction per control tick on in_ch (valid/ready). Each
// transaction yields exactly one result transaction on out_ch.
// An enabled tick runs four products (feedforward gain, filter alpha,
// integrator gain or leak, rate damping) through one serial multiplier that
// retires two bits per cycle. A disabled tick skips the products and goes
// from ST_PREP straight to ST_DONE.
// One tick is processed at a time; in_ch.ready is high only while the core
// is idle and the output register is empty, so no new tick is accepted
// until the last result has been taken. The result sits in an output
// register until taken; while the receiver stalls, no new transaction is
// accepted. Reset clears profile, feedforward and integrator state and
// reloads the configuration registers with their defaults. Configuration
// is written through the APB-style cfg_ port, by the user only while the
// core is idle; the block itself does not enforce this.
`default_nettype none
module gimbal_yaw_pitch_servo_step_core
  import gys_pkg::*;
#(
  parameter int CfgAddrWidth = 5
) (
  input  wire logic clk,
  input  wire logic rst_n,
  gys_in_if.sink in_ch,
  gys_out_if.source out_ch,
  input  wire logic cfg_psel,
  input  wire logic cfg_penable,
  input  wire logic cfg_pwrite,
  input  wire logic [CfgAddrWidth-1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  logic [14:0] mid_en_r, mid_ex_r, hi_en_r, hi_ex_r, iwin_r;
  logic ffneg_r;
  logic [2:0] cidx;
  assign cidx = 3'(cfg_paddr >> 2);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_en_r <= 15'd4480; mid_ex_r <= 15'd3520; hi_en_r <= 15'd7680;
      hi_ex_r <= 15'd5760; iwin_r <= 15'd983; ffneg_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr >> 5) == 0) begin
      case (cidx)
        CFG_MID_ENTER: mid_en_r <= cfg_pwdata[14:0];
        CFG_MID_EXIT: mid_ex_r <= cfg_pwdata[14:0];
        CFG_HIGH_ENTER: hi_en_r <= cfg_pwdata[14:0];
        CFG_HIGH_EXIT: hi_ex_r <= cfg_pwdata[14:0];
        CFG_IWIN: iwin_r <= cfg_pwdata[14:0];
        CFG_FFNEG: ffneg_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cidx)
      CFG_MID_ENTER: cfg_prdata = {17'd0, mid_en_r};
      CFG_MID_EXIT: cfg_prdata = {17'd0, mid_ex_r};
      CFG_HIGH_ENTER: cfg_prdata = {17'd0, hi_en_r};
      CFG_HIGH_EXIT: cfg_prdata = {17'd0, hi_ex_r};
      CFG_IWIN: cfg_prdata = {17'd0, iwin_r};
      CFG_FFNEG: cfg_prdata = {31'd0, ffneg_r};
      default: cfg_prdata = '0;
    endcase
  end

  state_t st_r, st_nxt;
  logic [1:0] prof_r, prof_nxt;
  logic chg_r, chg_nxt;
  logic signed [23:0] ff_r, ff_nxt;
  logic signed [23:0] ig_r, ig_nxt;
  logic signed [17:0] err_r, err_nxt;
  logic signed [15:0] cr_r, gr_r, my_r;
  logic signed [17:0] pit_r;
  logic en_r;
  logic ileak_r, ileak_nxt;
  logic signed [15:0] o_yaw_r, o_ff_r;
  logic signed [11:0] o_pit_r;
  logic [1:0] o_prof_r;
  logic o_chg_r, o_dv_r, o_valid_r;
  logic signed [15:0] o_yaw_nxt, o_ff_nxt;
  prof_k_t k, kn;
  logic accept, mstart, mdone;
  logic signed [25:0] ma;
  logic [15:0] mb;
  logic signed [42:0] mp;

  assign k = prof_k(prof_r);
  assign kn = prof_k(prof_nxt);
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == ST_IDLE) && !o_valid_r;

  gys_sermul u_mul (.clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb),
                    .done(mdone), .p(mp));

  function automatic logic signed [42:0] rnd(input logic signed [42:0] v, input int s);
    logic signed [42:0] t;
    t = v + (43'sd1 <<< (s - 1));
    return t >>> s;
  endfunction

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (accept) st_nxt = ST_PREP;
      ST_PREP: st_nxt = en_r ? ST_FFMUL : ST_DONE;
      ST_FFMUL: if (mdone) st_nxt = ST_ALPHA;
      ST_ALPHA: if (mdone) st_nxt = ST_INT;
      ST_INT: if (mdone) st_nxt = ST_DAMP;
      ST_DAMP: if (mdone) st_nxt = ST_DONE;
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  logic [15:0] acr;
  logic signed [17:0] e0, e1, ae;
  logic signed [24:0] d;
  logic signed [23:0] ffs, t43;
  logic signed [42:0] r0, ysum;
  logic signed [23:0] ai;

  always_comb begin
    prof_nxt = prof_r; chg_nxt = chg_r; ff_nxt = ff_r; ig_nxt = ig_r;
    err_nxt = err_r; ileak_nxt = ileak_r;
    o_yaw_nxt = o_yaw_r; o_ff_nxt = o_ff_r;
    mstart = 1'b0; ma = '0; mb = '0;
    acr = cr_r[15] ? 16'(-cr_r) : 16'(cr_r);
    e0 = '0; e1 = '0; ae = '0; d = '0; ffs = '0; t43 = '0; r0 = '0; ysum = '0; ai = '0;
    case (st_r)
      ST_PREP: begin
        if (!en_r) begin
          ff_nxt = '0; ig_nxt = '0; chg_nxt = 1'b0;
          o_yaw_nxt = '0; o_ff_nxt = '0;
        end else begin
          chg_nxt = 1'b1;
          if (prof_r != PROF_HIGH && acr >= {1'b0, hi_en_r}) prof_nxt = PROF_HIGH;
          else if (prof_r == PROF_HIGH && acr <= {1'b0, hi_ex_r})
            prof_nxt = (acr >= {1'b0, mid_en_r}) ? PROF_MID : PROF_NORMAL;
          else if (prof_r == PROF_NORMAL && acr >= {1'b0, mid_en_r}) prof_nxt = PROF_MID;
          else if (prof_r == PROF_MID && acr <= {1'b0, mid_ex_r}) prof_nxt = PROF_NORMAL;
          else chg_nxt = 1'b0;
          mstart = 1'b1;
          ma = 26'(cr_r);
          mb = kn.ffgain;
          e0 = err_r;
          if (e0 > PI_Q) e1 = e0 - TWO_PI_Q;
          else if (e0 < -PI_Q) e1 = e0 + TWO_PI_Q;
          else e1 = e0;
          ae = e1[17] ? -e1 : e1;
          if (ae < 18'(kn.deadband)) e1 = '0;
          err_nxt = e1;
        end
      end
      ST_FFMUL: if (mdone) begin
        r0 = rnd(mp, FiltFracBits - Ffx);
        if (ffneg_r) r0 = -r0;
        if (r0 > $signed(43'(k.fflim))) r0 = $signed(43'(k.fflim));
        else if (r0 < -$signed(43'(k.fflim))) r0 = -$signed(43'(k.fflim));
        d = 25'(r0) - 25'(ff_r);
        if (d > $signed(k.ffstep)) d = 25'(k.ffstep);
        else if (d < -$signed(k.ffstep)) d = -25'(k.ffstep);
        ffs = ff_r + 24'(d);
        ff_nxt = ffs;
        mstart = 1'b1;
        ma = 26'(r0) - 26'(ffs);
        mb = k.alpha;
      end
      ST_ALPHA: if (mdone) begin
        ff_nxt = ff_r + 24'(rnd(mp, FiltFracBits));
        ae = err_r[17] ? -err_r : err_r;
        ileak_nxt = !(ae < 18'(iwin_r));
        mstart = 1'b1;
        if (ileak_nxt) begin
          ai = ig_r[23] ? -ig_r : ig_r;
          ma = 26'(ai);
          mb = LEAK_Q;
        end else begin
          ma = 26'(err_r);
          mb = k.igain;
        end
      end
      ST_INT: if (mdone) begin
        if (ileak_r) begin
          t43 = 24'(mp >>> FiltFracBits);
          ig_nxt = ig_r[23] ? -t43 : t43;
        end else begin
          r0 = 43'(ig_r) + rnd(mp, FiltFracBits);
          if (r0 > $signed(43'(k.ilim))) r0 = $signed(43'(k.ilim));
          else if (r0 < -$signed(43'(k.ilim))) r0 = -$signed(43'(k.ilim));
          ig_nxt = 24'(r0);
        end
        mstart = 1'b1;
        ma = 26'(gr_r);
        mb = k.damp;
      end
      ST_DAMP: if (mdone) begin
        ysum = 43'(my_r) + 43'(err_r) + rnd(43'(ig_r), Ix) - rnd(mp, FiltFracBits);
        if (ysum > 43'sd32767) o_yaw_nxt = 16'sh7fff;
        else if (ysum < -43'sd32768) o_yaw_nxt = -16'sd32768;
        else o_yaw_nxt = 16'(ysum);
        r0 = rnd(43'(ff_r), Ffx);
        if (r0 > 43'sd32767) o_ff_nxt = 16'sh7fff;
        else if (r0 < -43'sd32768) o_ff_nxt = -16'sd32768;
        else o_ff_nxt = 16'(r0);
      end
      default: ;
    endcase
  end

  logic signed [17:0] pe;
  assign pe = 18'(in_ch.motor_pitch) - (18'(in_ch.pitch_target) - 18'(in_ch.gimbal_pitch));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; prof_r <= '0; ff_r <= '0; ig_r <= '0;
      o_valid_r <= 1'b0; chg_r <= 1'b0; ileak_r <= 1'b0;
    end else begin
      st_r <= st_nxt; prof_r <= prof_nxt; ff_r <= ff_nxt; ig_r <= ig_nxt;
      chg_r <= chg_nxt; ileak_r <= ileak_nxt;
      if (st_r == ST_DONE) o_valid_r <= 1'b1;
      else if (out_ch.ready) o_valid_r <= 1'b0;
    end
    o_yaw_r <= o_yaw_nxt; o_ff_r <= o_ff_nxt;
    if (accept) begin
      en_r <= in_ch.enable; cr_r <= in_ch.chassis_rate; gr_r <= in_ch.gimbal_rate;
      my_r <= in_ch.motor_yaw;
      err_r <= 18'(in_ch.yaw_target) - 18'(in_ch.gimbal_yaw);
      if (pe > PITCH_UP) pit_r <= PITCH_UP;
      else if (pe < PITCH_DOWN) pit_r <= PITCH_DOWN;
      else pit_r <= pe;
    end else begin
      err_r <= err_nxt;
    end
    if (st_r == ST_DONE) begin
      o_prof_r <= prof_r; o_chg_r <= chg_r && en_r; o_dv_r <= en_r;
      o_pit_r <= en_r ? 12'(pit_r) : '0;
    end
  end

  assign out_ch.valid = o_valid_r;
  assign out_ch.yaw_drive = o_yaw_r;
  assign out_ch.yaw_feedforward = o_ff_r;
  assign out_ch.pitch_drive = o_pit_r;
  assign out_ch.profile = o_prof_r;
  assign out_ch.profile_changed = o_chg_r;
  assign out_ch.drive_valid = o_dv_r;
endmodule
`default_nettype wire

// ===== hdl/gys_checker.sv =====
// Port-level checker for the servo step core, attached by bind.
// Depends on the top level's ports only.
`default_nettype none
module gys_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic drive_valid,
  input wire logic profile_changed,
  input wire logic [1:0] profile
);
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");
  a_prof: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> profile != 2'd3) else $error("bad profile");
  a_chg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && profile_changed |-> drive_valid) else $error("change while disabled");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

bind gimbal_yaw_pitch_servo_step_core gys_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .drive_valid(out_ch.drive_valid),
  .profile_changed(out_ch.profile_changed), .profile(out_ch.profile));
`default_nettype wire

// ===== tb/sv/gimbal_yaw_pitch_servo_step_core_tb.sv =====
// Testbench for gimbal_yaw_pitch_servo_step_core: random valid/ready traffic, APB setup
// writes, and a self-contained per-tick predictor checked field by field.
// Depends on gys_pkg, gys_if and the core RTL.
`timescale 1ns / 100ps
`default_nettype none
module gimbal_yaw_pitch_servo_step_core_tb;
  import gys_pkg::*;

  typedef struct {
    logic en;
    logic signed [15:0] yt, gy, my, cr, gr, pt, gp, mp;
  } tick_t;

  typedef struct {
    logic signed [15:0] yaw, ff;
    logic signed [11:0] pitch;
    logic [1:0] prof;
    logic chg, dv;
  } drive_t;

  localparam logic [2:0] CFG_SPARE = 3'd6;
  localparam longint PiQ = 12868;
  localparam longint LeakQ = 16302;
  localparam longint PitchUp = 1434;
  localparam longint PitchDown = -1843;

  localparam longint DeadbandK[3] = '{16, 20, 18};
  localparam longint DampK[3] = '{0, 1258, 1468};
  localparam longint FfGainK[3] = '{32768, 35226, 37683};
  localparam longint FfLimK[3] = '{3276800, 3768320, 4587520};
  localparam longint FfStepK[3] = '{26214, 32768, 39322};
  localparam longint AlphaK[3] = '{655, 524, 492};
  localparam longint IGainK[3] = '{2307, 3020, 3607};
  localparam longint ILimK[3] = '{52429, 73400, 94372};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  gys_in_if in_ch ();
  gys_out_if out_ch ();

  gimbal_yaw_pitch_servo_step_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  tick_t pending_ticks[$];
  drive_t expected_drives[$];
  longint thr[5];
  logic ff_negate;
  profile_t prof_q;
  longint ff_acc, integ_acc;
  int fail_cnt = 0;
  bit tick_taken = 0;
  bit quiet = 0;
  int gap_pct = 25;
  int in_gap = 0, out_stall = 0;
  longint cr_walk = 0;

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic drive_t servo_predict(tick_t t);
    drive_t r;
    longint a, err, raw, d, yaw, pit, m;
    int p;
    r.chg = 1'b0;
    if (!t.en) begin
      ff_acc = 0;
      integ_acc = 0;
      r.yaw = '0; r.ff = '0; r.pitch = '0; r.prof = prof_q; r.dv = 1'b0;
      return r;
    end
    a = mag(longint'(t.cr));
    if (prof_q != PROF_HIGH && a >= thr[CFG_HIGH_ENTER]) begin
      prof_q = PROF_HIGH; r.chg = 1'b1;
    end else if (prof_q == PROF_HIGH && a <= thr[CFG_HIGH_EXIT]) begin
      prof_q = (a >= thr[CFG_MID_ENTER]) ? PROF_MID : PROF_NORMAL; r.chg = 1'b1;
    end else if (prof_q == PROF_NORMAL && a >= thr[CFG_MID_ENTER]) begin
      prof_q = PROF_MID; r.chg = 1'b1;
    end else if (prof_q == PROF_MID && a <= thr[CFG_MID_EXIT]) begin
      prof_q = PROF_NORMAL; r.chg = 1'b1;
    end
    p = int'(prof_q);
    err = longint'(t.yt) - longint'(t.gy);
    if (err > PiQ) err -= 2 * PiQ;
    else if (err < -PiQ) err += 2 * PiQ;
    if (mag(err) < DeadbandK[p]) err = 0;
    raw = round_shift(longint'(t.cr) * FfGainK[p], FiltFracBits - Ffx);
    if (ff_negate) raw = -raw;
    raw = clip(raw, -FfLimK[p], FfLimK[p]);
    d = clip(raw - ff_acc, -FfStepK[p], FfStepK[p]);
    ff_acc += d;
    ff_acc += round_shift(AlphaK[p] * (raw - ff_acc), FiltFracBits);
    if (mag(err) < thr[CFG_IWIN]) begin
      integ_acc += round_shift(err * IGainK[p], FiltFracBits);
      integ_acc = clip(integ_acc, -ILimK[p], ILimK[p]);
    end else begin
      m = (mag(integ_acc) * LeakQ) >>> FiltFracBits;
      integ_acc = integ_acc < 0 ? -m : m;
    end
    yaw = longint'(t.my) + err + round_shift(integ_acc, Ix)
          - round_shift(longint'(t.gr) * DampK[p], FiltFracBits);
    pit = clip(longint'(t.mp) - (longint'(t.pt) - longint'(t.gp)), PitchDown, PitchUp);
    r.yaw = 16'(clip(yaw, -32768, 32767));
    r.ff = 16'(clip(round_shift(ff_acc, Ffx), -32768, 32767));
    r.pitch = 12'(pit);
    r.prof = prof_q;
    r.dv = 1'b1;
    return r;
  endfunction

  // sender
  always @(negedge clk) begin
    if (tick_taken || !in_ch.valid) begin
      tick_taken = 0;
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_ticks.size() > 0) begin
        tick_t t;
        t = pending_ticks.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.enable <= t.en;
        in_ch.yaw_target <= t.yt;
        in_ch.gimbal_yaw <= t.gy;
        in_ch.motor_yaw <= t.my;
        in_ch.chassis_rate <= t.cr;
        in_ch.gimbal_rate <= t.gr;
        in_ch.pitch_target <= t.pt;
        in_ch.gimbal_pitch <= t.gp;
        in_ch.motor_pitch <= t.mp;
        if (!quiet && $urandom_range(99) < gap_pct) in_gap = $urandom_range(1, 11);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!quiet && $urandom_range(99) < gap_pct) out_stall = $urandom_range(1, 11);
    end
  end

  // input capture and result check
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      tick_t t;
      t.en = in_ch.enable; t.yt = in_ch.yaw_target; t.gy = in_ch.gimbal_yaw;
      t.my = in_ch.motor_yaw; t.cr = in_ch.chassis_rate; t.gr = in_ch.gimbal_rate;
      t.pt = in_ch.pitch_target; t.gp = in_ch.gimbal_pitch; t.mp = in_ch.motor_pitch;
      expected_drives.push_back(servo_predict(t));
      tick_taken = 1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_drives.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected result transaction at %0t", $time);
      end else begin
        drive_t e;
        e = expected_drives.pop_front();
        if (out_ch.yaw_drive !== e.yaw || out_ch.yaw_feedforward !== e.ff ||
            out_ch.pitch_drive !== e.pitch || out_ch.profile !== e.prof ||
            out_ch.profile_changed !== e.chg || out_ch.drive_valid !== e.dv) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch at %0t: exp yaw %0d ff %0d pitch %0d prof %0d chg %0b dv %0b",
                     $time, e.yaw, e.ff, e.pitch, e.prof, e.chg, e.dv,
                     " got yaw %0d ff %0d pitch %0d prof %0d chg %0b dv %0b",
                     out_ch.yaw_drive, out_ch.yaw_feedforward, out_ch.pitch_drive,
                     out_ch.profile, out_ch.profile_changed, out_ch.drive_valid);
        end
      end
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (idx == CFG_FFNEG) ff_negate = val[0];
    else if (idx < CFG_FFNEG) thr[idx] = longint'(val[14:0]);
  endtask

  task automatic drain;
    wait (pending_ticks.size() == 0 && !in_ch.valid && expected_drives.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic add_tick(logic en, int yt, int gy, int my, int cr, int gr,
                          int pt, int gp, int mp);
    tick_t t;
    t.en = en; t.yt = 16'(yt); t.gy = 16'(gy); t.my = 16'(my); t.cr = 16'(cr);
    t.gr = 16'(gr); t.pt = 16'(pt); t.gp = 16'(gp); t.mp = 16'(mp);
    pending_ticks.push_back(t);
  endtask

  task automatic add_random(int n);
    int k, gy, cr;
    repeat (n) begin
      k = $urandom_range(9);
      if (k == 0) begin
        add_tick($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom);
      end else if (k == 1) begin
        add_tick(1'b0, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom);
      end else begin
        cr_walk = clip(cr_walk + $urandom_range(1400) - 700, -12000, 12000);
        cr = (k == 2) ? $urandom_range(16000) - 8000 : int'(cr_walk);
        gy = $urandom;
        add_tick(1'b1, gy + ((k < 6) ? $urandom_range(200) - 100 : $urandom_range(3000) - 1500),
                 gy, $urandom, cr, $urandom_range(8000) - 4000,
                 $urandom_range(4000) - 2000, $urandom_range(4000) - 2000, $urandom);
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.enable = 1'b0;
    in_ch.yaw_target = '0; in_ch.gimbal_yaw = '0; in_ch.motor_yaw = '0;
    in_ch.chassis_rate = '0; in_ch.gimbal_rate = '0; in_ch.pitch_target = '0;
    in_ch.gimbal_pitch = '0; in_ch.motor_pitch = '0;
    out_ch.ready = 1'b0;
    thr[CFG_MID_ENTER] = 4480; thr[CFG_MID_EXIT] = 3520;
    thr[CFG_HIGH_ENTER] = 7680; thr[CFG_HIGH_EXIT] = 5760; thr[CFG_IWIN] = 983;
    ff_negate = 1'b0;
    prof_q = PROF_NORMAL; ff_acc = 0; integ_acc = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: disable, field extremes, wrap, deadband, profile walk, pitch limits
    add_tick(0, 100, 0, 5, 9000, 0, 0, 0, 0);
    add_tick(1, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    add_tick(1, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    add_tick(1, 32767, -32768, 0, 0, 0, 0, 0, 0);
    add_tick(1, -32768, 32767, 0, 0, 0, 0, 0, 0);
    add_tick(1, 13000, 0, 100, 0, 0, 0, 0, 0);
    add_tick(1, -13000, 0, 100, 0, 0, 0, 0, 0);
    add_tick(1, 15, 0, 0, 0, 0, 0, 0, 0);
    add_tick(1, 400, 0, 0, 4480, 1000, 0, 0, 0);
    add_tick(1, 400, 0, 0, -7680, -1000, 0, 0, 0);
    add_tick(1, 400, 0, 0, 6000, 500, 0, 0, 0);
    add_tick(1, 400, 0, 0, 5760, 500, 0, 0, 0);
    add_tick(1, -400, 0, 0, 3520, 0, 0, 0, 0);
    add_tick(1, 17, 0, 0, 0, 0, 0, 0, 0);
    add_tick(1, 0, 0, 0, 0, 0, 5000, 0, 0);
    add_tick(1, 0, 0, 0, 0, 0, -5000, 0, 0);
    add_tick(1, 0, 0, 0, 0, 0, 0, 0, 1434);
    add_tick(1, 0, 0, 0, 0, 0, 0, 0, -1843);
    add_tick(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_tick(1, 2000, 0, -32000, 20000, 30000, 0, 0, 0);
    drain();

    cfg_write(CFG_MID_ENTER, 32'd2000);
    cfg_write(CFG_MID_EXIT, 32'd1500);
    cfg_write(CFG_HIGH_ENTER, 32'd5000);
    cfg_write(CFG_HIGH_EXIT, 32'd4000);
    cfg_write(CFG_IWIN, 32'd32767);
    cfg_write(CFG_FFNEG, 32'd1);
    cfg_write(CFG_SPARE, 32'hFFFF_FFFF);
    add_random(130);
    drain();

    // extremes: zero thresholds and zero window
    gap_pct = 0;
    cfg_write(CFG_MID_ENTER, 32'd0);
    cfg_write(CFG_MID_EXIT, 32'd0);
    cfg_write(CFG_HIGH_ENTER, 32'd0);
    cfg_write(CFG_HIGH_EXIT, 32'd0);
    cfg_write(CFG_IWIN, 32'd0);
    add_random(60);
    drain();

    // inconsistent thresholds, all maximum
    gap_pct = 40;
    cfg_write(CFG_MID_ENTER, 32'hFFFF_FFFF);
    cfg_write(CFG_MID_EXIT, 32'd32767);
    cfg_write(CFG_HIGH_ENTER, 32'd32767);
    cfg_write(CFG_HIGH_EXIT, 32'd32767);
    cfg_write(CFG_FFNEG, 32'd0);
    add_random(60);
    drain();

    cfg_write(CFG_MID_ENTER, 32'd8000);
    cfg_write(CFG_MID_EXIT, 32'd9000);
    cfg_write(CFG_HIGH_ENTER, 32'd3000);
    cfg_write(CFG_HIGH_EXIT, 32'd6000);
    cfg_write(CFG_IWIN, $urandom_range(32767));
    add_random(60);
    drain();

    // back to defaults for the bulk of the traffic
    gap_pct = 25;
    cfg_write(CFG_MID_ENTER, 32'd4480);
    cfg_write(CFG_MID_EXIT, 32'd3520);
    cfg_write(CFG_HIGH_ENTER, 32'd7680);
    cfg_write(CFG_HIGH_EXIT, 32'd5760);
    cfg_write(CFG_IWIN, 32'd983);
    cfg_write(CFG_FFNEG, $urandom_range(1));
    add_random(180);
    wait (pending_ticks.size() == 0);
    quiet = 1;
    add_random(60);
    wait (pending_ticks.size() == 0 && !in_ch.valid && expected_drives.size() == 0);
    repeat (60) @(posedge clk);
    if (expected_drives.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
